[src/ustc_pkg.sv]
// ----------------------------------------------------------------------------
// ustc_pkg: shared constants, types and tables
// Reciprocal constants for the divisions by fixed numbers, the month-start
// table and the days-before-year helper used by the conversion pipeline.
// ----------------------------------------------------------------------------
package ustc_pkg;

  localparam int SecsW  = 32;
  localparam int DaysW  = 16;
  localparam int RemW   = 17;
  localparam int OffW   = 8;
  localparam int DoyW   = 9;
  localparam int YearW  = 12;
  localparam int MonW   = 4;
  localparam int DayW   = 5;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;
  localparam int HrRemW = 12;

  // seconds / 86400 == (seconds >> 7) / 675
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam int          DayShift  = 35;
  localparam logic [16:0] YearRecip = 17'd91930;
  localparam int          YearShift = 25;
  localparam logic [17:0] HourRecip = 18'd149131;
  localparam int          HourShift = 29;
  localparam logic [12:0] MinRecip  = 13'd4370;
  localparam int          MinShift  = 18;

  localparam logic [16:0]     SecsPerDay  = 17'd86400;
  localparam logic [11:0]     SecsPerHour = 12'd3600;
  localparam logic [5:0]      SecsPerMin  = 6'd60;
  localparam logic [8:0]      DaysPerYear = 9'd365;
  localparam logic [YearW-1:0] BaseYear   = 12'd1970;
  // year 2100 as an offset from the base year
  localparam logic [OffW-1:0] CenturyOff  = 8'd130;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DayW-1:0]  day;
  } cal_t;

  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } hms_t;

  // days from the base date to the first day of year base + off
  function automatic logic [DaysW-1:0] days_before(input logic [OffW-1:0] off);
    logic [OffW:0]      off_inc;
    logic [DaysW-1:0]   leaps;
    logic [DaysW-1:0]   common;
    off_inc = {1'b0, off} + {{OffW{1'b0}}, 1'b1};
    leaps   = DaysW'(off_inc >> 2);
    if (off > CenturyOff) begin
      leaps = leaps - {{(DaysW-1){1'b0}}, 1'b1};
    end
    common = DaysW'(DaysW'(off) * DaysW'(DaysPerYear));
    return common + leaps;
  endfunction

  function automatic logic [DoyW-1:0] month_start(input logic leap,
                                                  input logic [MonW-1:0] mon);
    logic [DoyW-1:0] base;
    unique case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (mon > 4'd1)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

[src/ustc_date_pipe.sv]
// ----------------------------------------------------------------------------
// ustc_date_pipe: day count to calendar date
// Five register stages: year estimate, year correction and day of year,
// month search and day of month, then two alignment stages.
// ----------------------------------------------------------------------------
module ustc_date_pipe (
  input  logic                      clk,
  input  logic [ustc_pkg::DaysW-1:0] days,
  output ustc_pkg::cal_t            cal
);
  import ustc_pkg::*;

  logic [DaysW-1:0] days_d2;
  logic [OffW-1:0]  off_d2;
  logic [32:0]      year_prod;

  logic [DoyW-1:0]  doy_d3;
  logic [YearW-1:0] year_d3;
  logic             leap_d3;

  cal_t cal_d4;
  cal_t cal_d5;
  cal_t cal_d6;

  logic [DaysW-1:0] before_a;
  logic [DaysW-1:0] before_b;
  logic [DaysW-1:0] before_sel;
  logic [OffW-1:0]  off_dec;
  logic [OffW-1:0]  off_sel;
  logic [DaysW-1:0] doy_full;

  logic [MonW-1:0]  mon;
  logic [DoyW-1:0]  mon_base;
  logic [DoyW-1:0]  day_full;

  // days / 365 estimate
  assign year_prod = days * YearRecip;

  always_ff @(posedge clk) begin
    days_d2 <= days;
    off_d2  <= year_prod[YearShift +: OffW];
  end

  // estimate is at most one year high
  always_comb begin
    off_dec  = off_d2 - {{(OffW-1){1'b0}}, 1'b1};
    before_a = days_before(off_d2);
    before_b = days_before(off_dec);
    if ((off_d2 != '0) && (days_d2 < before_a)) begin
      off_sel    = off_dec;
      before_sel = before_b;
    end else begin
      off_sel    = off_d2;
      before_sel = before_a;
    end
    doy_full = days_d2 - before_sel;
  end

  always_ff @(posedge clk) begin
    doy_d3  <= doy_full[DoyW-1:0];
    year_d3 <= BaseYear + YearW'(off_sel);
    leap_d3 <= (off_sel[1:0] == 2'd2) && (off_sel != CenturyOff);
  end

  // month search over the start table
  always_comb begin
    mon = '0;
    for (int m = 1; m < 12; m++) begin
      if (doy_d3 >= month_start(leap_d3, MonW'(m))) begin
        mon = MonW'(m);
      end
    end
    mon_base = month_start(leap_d3, mon);
    day_full = doy_d3 - mon_base + {{(DoyW-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    cal_d4.year  <= year_d3;
    cal_d4.month <= mon + {{(MonW-1){1'b0}}, 1'b1};
    cal_d4.day   <= day_full[DayW-1:0];
    cal_d5       <= cal_d4;
    cal_d6       <= cal_d5;
  end

  assign cal = cal_d6;

endmodule

[src/ustc_time_pipe.sv]
// ----------------------------------------------------------------------------
// ustc_time_pipe: seconds of day to hour, minute and second
// Five register stages: seconds of day, hour, remainder of hour, minute,
// then second.
// ----------------------------------------------------------------------------
module ustc_time_pipe (
  input  logic                      clk,
  input  logic [ustc_pkg::SecsW-1:0] secs,
  input  logic [ustc_pkg::DaysW-1:0] days,
  output ustc_pkg::hms_t            hms
);
  import ustc_pkg::*;

  logic [32:0]        day_prod;
  logic [SecsW-1:0]   rem_full;
  logic [RemW-1:0]    rem_t2;

  logic [34:0]        hour_prod;
  logic [RemW-1:0]    rem_t3;
  logic [HourW-1:0]   hour_t3;

  logic [RemW-1:0]    hour_secs;
  logic [RemW-1:0]    hrem_full;
  logic [HrRemW-1:0]  hrem_t4;
  logic [HourW-1:0]   hour_t4;

  logic [24:0]        min_prod;
  logic [HrRemW-1:0]  hrem_t5;
  logic [HourW-1:0]   hour_t5;
  logic [MinW-1:0]    min_t5;

  logic [HrRemW-1:0]  min_secs;
  logic [HrRemW-1:0]  sec_full;

  hms_t hms_t6;

  assign day_prod = days * SecsPerDay;
  assign rem_full = secs - day_prod[SecsW-1:0];

  always_ff @(posedge clk) begin
    rem_t2 <= rem_full[RemW-1:0];
  end

  assign hour_prod = rem_t2 * HourRecip;

  always_ff @(posedge clk) begin
    rem_t3  <= rem_t2;
    hour_t3 <= hour_prod[HourShift +: HourW];
  end

  assign hour_secs = hour_t3 * SecsPerHour;
  assign hrem_full = rem_t3 - hour_secs;

  always_ff @(posedge clk) begin
    hour_t4 <= hour_t3;
    hrem_t4 <= hrem_full[HrRemW-1:0];
  end

  assign min_prod = hrem_t4 * MinRecip;

  always_ff @(posedge clk) begin
    hour_t5 <= hour_t4;
    hrem_t5 <= hrem_t4;
    min_t5  <= min_prod[MinShift +: MinW];
  end

  assign min_secs = min_t5 * SecsPerMin;
  assign sec_full = hrem_t5 - min_secs;

  always_ff @(posedge clk) begin
    hms_t6.hour   <= hour_t5;
    hms_t6.minute <= min_t5;
    hms_t6.second <= sec_full[SecW-1:0];
  end

  assign hms = hms_t6;

endmodule

[src/unix_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar: epoch seconds to calendar date and time of day
// The valid shift register tracks each accepted request to done; one request
// per cycle, busy stays low since every stage advances each cycle.
// Throughput is set by the six-stage multiply pipeline, one result per cycle.
// Synchronous active-high reset clears the valid bits; results need no drain.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [ustc_pkg::SecsW-1:0] epoch_seconds,
  output logic                       done,
  output logic [ustc_pkg::YearW-1:0] cal_year,
  output logic [ustc_pkg::MonW-1:0]  cal_month,
  output logic [ustc_pkg::DayW-1:0]  cal_day,
  output logic [ustc_pkg::HourW-1:0] clock_hour,
  output logic [ustc_pkg::MinW-1:0]  clock_minute,
  output logic [ustc_pkg::SecW-1:0]  clock_second
);
  import ustc_pkg::*;

  localparam int Depth = 6;

  logic [Depth-1:0] vld;
  logic [Depth-1:0] vld_next;
  logic             take;

  logic [50:0]      day_prod;
  logic [SecsW-1:0] secs_s1;
  logic [DaysW-1:0] days_s1;

  cal_t cal;
  hms_t hms;

  assign busy = 1'b0;
  assign take = start && !busy;

  // seconds / 86400 by reciprocal of 675 after dropping 7 bits
  assign day_prod = epoch_seconds[SecsW-1:7] * DayRecip;

  always_ff @(posedge clk) begin
    secs_s1 <= epoch_seconds;
    days_s1 <= day_prod[DayShift +: DaysW];
  end

  assign vld_next = {vld[Depth-2:0], take};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  ustc_date_pipe u_date (
    .clk  (clk),
    .days (days_s1),
    .cal  (cal)
  );

  ustc_time_pipe u_time (
    .clk  (clk),
    .secs (secs_s1),
    .days (days_s1),
    .hms  (hms)
  );

  assign done         = vld[Depth-1];
  assign cal_year     = cal.year;
  assign cal_month    = cal.month;
  assign cal_day      = cal.day;
  assign clock_hour   = hms.hour;
  assign clock_minute = hms.minute;
  assign clock_second = hms.second;

endmodule

[verif/ustc_date_checker.sv]
// ----------------------------------------------------------------------------
// ustc_date_checker: prediction and comparison for unix_seconds_to_calendar
// Watches the request and result channels. Each accepted request is converted
// to an expected date and time of day by an independent Gregorian calendar
// model. The expectation is queued and then compared field by field with the
// next strobed result. Mismatches and the number of outstanding expectations
// are handed back to the testbench top.
// ----------------------------------------------------------------------------
module ustc_date_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [ustc_pkg::SecsW-1:0] epoch_seconds,
  input  logic                       done,
  input  logic [ustc_pkg::YearW-1:0] cal_year,
  input  logic [ustc_pkg::MonW-1:0]  cal_month,
  input  logic [ustc_pkg::DayW-1:0]  cal_day,
  input  logic [ustc_pkg::HourW-1:0] clock_hour,
  input  logic [ustc_pkg::MinW-1:0]  clock_minute,
  input  logic [ustc_pkg::SecW-1:0]  clock_second,
  output int                         mismatches,
  output int                         dates_outstanding
);
  import ustc_pkg::*;

  typedef struct packed {
    logic [SecsW-1:0] secs;
    cal_t             date;
    hms_t             tod;
  } stamp_t;

  localparam int unsigned MonthFirstDay [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };
  localparam int unsigned EpochYear = 1970;

  stamp_t pending_dates [$];
  int     mismatch_total = 0;

  // days from the epoch to january 1st of epoch year + year_off
  function automatic int unsigned days_to_year(input int unsigned year_off);
    int unsigned prev;
    int unsigned epoch_prev;
    prev       = EpochYear - 1 + year_off;
    epoch_prev = EpochYear - 1;
    return 365 * year_off + (prev / 4 - prev / 100 + prev / 400)
           - (epoch_prev / 4 - epoch_prev / 100 + epoch_prev / 400);
  endfunction

  function automatic stamp_t epoch_to_date(input logic [SecsW-1:0] secs);
    int unsigned day_count;
    int unsigned day_secs;
    int unsigned year_off;
    int unsigned year_first;
    int unsigned year_full;
    int unsigned leap_adj;
    int unsigned month_idx;
    int unsigned month_base;
    stamp_t      s;
    day_count  = secs / 86400;
    day_secs   = secs % 86400;
    year_off   = day_count / 365;
    year_first = days_to_year(year_off);
    while (year_off > 0 && day_count < year_first) begin
      year_off--;
      year_first = days_to_year(year_off);
    end
    day_count -= year_first;
    year_full = EpochYear + year_off;
    leap_adj  = (((year_full % 4 == 0) && (year_full % 100 != 0)) || (year_full % 400 == 0))
                ? 1 : 0;
    month_idx  = 11;
    month_base = MonthFirstDay[11] + leap_adj;
    while (month_idx > 0 && day_count < month_base) begin
      month_idx--;
      month_base = MonthFirstDay[month_idx] + ((month_idx >= 2) ? leap_adj : 0);
    end
    s.secs       = secs;
    s.date.year  = YearW'(year_full);
    s.date.month = MonW'(month_idx + 1);
    s.date.day   = DayW'(day_count - month_base + 1);
    s.tod.hour   = HourW'(day_secs / 3600);
    s.tod.minute = MinW'((day_secs % 3600) / 60);
    s.tod.second = SecW'(day_secs % 60);
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatch_total++;
  endtask

  task automatic compare_field(input string name, input logic [SecsW-1:0] secs,
                               input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("seconds %0d: %s got %0d expected %0d",
                                secs, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    stamp_t want;
    if (!rst) begin
      if (start && !busy) begin
        pending_dates.push_back(epoch_to_date(epoch_seconds));
      end
      if (done) begin
        if (pending_dates.size() == 0) begin
          report_mismatch($sformatf("result %0d-%0d-%0d %0d:%0d:%0d with no request pending",
                                    cal_year, cal_month, cal_day,
                                    clock_hour, clock_minute, clock_second));
        end else begin
          want = pending_dates.pop_front();
          compare_field("year",   want.secs, 32'(cal_year),     32'(want.date.year));
          compare_field("month",  want.secs, 32'(cal_month),    32'(want.date.month));
          compare_field("day",    want.secs, 32'(cal_day),      32'(want.date.day));
          compare_field("hour",   want.secs, 32'(clock_hour),   32'(want.tod.hour));
          compare_field("minute", want.secs, 32'(clock_minute), 32'(want.tod.minute));
          compare_field("second", want.secs, 32'(clock_second), 32'(want.tod.second));
        end
      end
    end
    mismatches        <= mismatch_total;
    dates_outstanding <= pending_dates.size();
  end

endmodule

[verif/unix_seconds_to_calendar_tb.sv]
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_tb: testbench for the epoch to calendar converter
// Sends directed timestamps (epoch, field extremes, leap days, century years,
// the last representable second) followed by random timestamps biased toward
// day, year and century boundaries, with random request gaps. The checker
// beside the block predicts and compares every result. A watchdog ends the
// run if nothing is accepted for too long.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_tb;
  import ustc_pkg::*;

  localparam int StallLimit = 1000;
  localparam int DrainCycles = 20;
  localparam int RandomRequests = 880;

  logic             clk;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [SecsW-1:0] epoch_seconds = '0;
  logic             done;
  logic [YearW-1:0] cal_year;
  logic [MonW-1:0]  cal_month;
  logic [DayW-1:0]  cal_day;
  logic [HourW-1:0] clock_hour;
  logic [MinW-1:0]  clock_minute;
  logic [SecW-1:0]  clock_second;
  int               mismatches;
  int               dates_outstanding;
  int               stall_cycles = 0;

  logic [SecsW-1:0] directed_secs [$] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd31535999, 32'd31536000, 32'd68169600, 32'd68255999,
    32'd946684799, 32'd946684800, 32'd951782400, 32'd951868800, 32'd978307199,
    32'd2147483647, 32'd2147483648,
    32'd4102444799, 32'd4102444800, 32'd4107456000, 32'd4107542400,
    32'd4294967294, 32'd4294967295
  };

  // jan 1st 2000, feb 29th 2000, jan 1st 2100, mar 1st 2100
  localparam longint CenturyMarks [4] = '{
    946684800, 951782400, 4102444800, 4107542400
  };

  unix_seconds_to_calendar i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .epoch_seconds(epoch_seconds),
    .done         (done),
    .cal_year     (cal_year),
    .cal_month    (cal_month),
    .cal_day      (cal_day),
    .clock_hour   (clock_hour),
    .clock_minute (clock_minute),
    .clock_second (clock_second)
  );

  ustc_date_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .epoch_seconds    (epoch_seconds),
    .done             (done),
    .cal_year         (cal_year),
    .cal_month        (cal_month),
    .cal_day          (cal_day),
    .clock_hour       (clock_hour),
    .clock_minute     (clock_minute),
    .clock_second     (clock_second),
    .mismatches       (mismatches),
    .dates_outstanding(dates_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == StallLimit) begin
        $display("unix_seconds_to_calendar_tb failed");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [SecsW-1:0] secs);
    start         <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (busy);
  endtask

  // random gap before the next request, with junk on the data port
  task automatic sender_gap(input bit allow_idle);
    if (allow_idle) begin
      while ($urandom_range(99) < 35) begin
        start         <= 1'b0;
        epoch_seconds <= $urandom;
        @(posedge clk);
      end
    end
  endtask

  task automatic wait_for_results;
    start <= 1'b0;
    @(posedge clk);
    while (dates_outstanding != 0) @(posedge clk);
  endtask

  initial begin
    longint           day_num;
    int               year_num;
    logic [SecsW-1:0] secs;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_secs[i]) begin
      sender_gap(1'b1);
      send_request(directed_secs[i]);
    end
    wait_for_results();

    for (int i = 0; i < RandomRequests; i++) begin
      if (i == 450) begin
        wait_for_results();
      end
      sender_gap(i < 300 || i >= 500);
      case ($urandom_range(5))
        0: secs = $urandom;
        1: secs = $urandom_range(200000);
        2: secs = 32'hFFFF_FFFF - $urandom_range(200000);
        3: begin
          day_num = $urandom_range(49709);
          secs    = 32'(day_num * 86400 + ($urandom_range(1) ? 86399 : $urandom_range(86399)));
        end
        4: begin
          // first second of a year or the last second before it
          year_num = $urandom_range(2106, 1971);
          day_num  = 365 * (year_num - 1970) + (year_num - 1) / 4 - (year_num - 1) / 100
                     + (year_num - 1) / 400 - 477;
          secs     = 32'(day_num * 86400 - $urandom_range(1));
        end
        default: begin
          secs = 32'(CenturyMarks[$urandom_range(3)] + longint'($urandom_range(518400))
                     - 259200);
        end
      endcase
      send_request(secs);
    end

    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("unix_seconds_to_calendar_tb passed");
    end else begin
      $display("unix_seconds_to_calendar_tb failed");
    end
    $finish;
  end

endmodule
